// ===== rtl/core/pwlp_pkg.sv =====
// ----------------------------------------------------------------------------
// pwlp_pkg: shared types and constants of the window/level palette mapper
// Item layouts, register indexes, state encodings and the control structs
// between the top level and the index divider.
// ----------------------------------------------------------------------------
package pwlp_pkg;

    localparam int PWLP_PALETTE_DEPTH = 256;
    localparam int PWLP_MAX_WINDOW    = 4096;

    // Number of quotient bits produced by the index divider.
    localparam int DIV_BITS  = 8;
    localparam int DIV_CNT_W = $clog2(DIV_BITS);

    localparam logic [7:0] INDEX_MAX = 8'd255;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOW_CUT       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HIGH_CUT      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_WIDTH  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_HEIGHT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIRROR_X      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIRROR_Y      = 3'd5;

    // Input item kinds.
    localparam logic KIND_PIXEL   = 1'b0;
    localparam logic KIND_PALETTE = 1'b1;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] pixel_value;
        logic [11:0]        column;
        logic [11:0]        row;
        logic [7:0]         palette_index;
        logic [23:0]        palette_color;
    } t_in_item;

    typedef struct packed {
        logic [23:0] color;
        logic [23:0] dest_index;
        logic [7:0]  color_index;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_READ
    } t_state;

    typedef enum logic [2:0] {
        DV_IDLE,
        DV_ABS,
        DV_CHECK,
        DV_ITER,
        DV_DONE
    } t_div_state;

    typedef struct packed {
        logic               start;
        logic signed [31:0] sample;
        logic signed [31:0] low_cut;
        logic signed [31:0] high_cut;
    } t_div_req;

    typedef struct packed {
        logic       done;
        logic [7:0] index;
    } t_div_rsp;

endpackage

// ===== rtl/core/pwlp_ram.sv =====
// ----------------------------------------------------------------------------
// pwlp_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pwlp_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/pwlp_div.sv =====
// ----------------------------------------------------------------------------
// pwlp_div: colour index divider
// Computes clamp(floor((sample-low)*256/(high-low)),0,255) with a
// restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pwlp_div
    import pwlp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    t_div_state r_state;
    t_div_state n_state;

    logic signed [32:0]   r_diff;
    logic signed [32:0]   r_span;
    logic [31:0]          r_mag_num;
    logic [31:0]          r_mag_den;
    logic                 r_span_zero;
    logic                 r_non_pos;
    logic                 r_diff_neg;
    logic [31:0]          r_rem;
    logic [7:0]           r_quot;
    logic [DIV_CNT_W-1:0] r_cnt;

    logic        early_exit;
    logic [32:0] shifted;
    logic        take;

    // Saturated or signed-out cases finish without iterating.
    assign early_exit = r_span_zero || r_non_pos || (r_mag_num >= r_mag_den);
    assign shifted    = {r_rem, 1'b0};
    assign take       = shifted >= {1'b0, r_mag_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DV_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            DV_IDLE: begin
                if (i_req.start) begin
                    n_state = DV_ABS;
                end
            end
            DV_ABS:   n_state = DV_CHECK;
            DV_CHECK: n_state = early_exit ? DV_DONE : DV_ITER;
            DV_ITER: begin
                if (r_cnt == DIV_CNT_W'(DIV_BITS - 1)) begin
                    n_state = DV_DONE;
                end
            end
            DV_DONE:  n_state = DV_IDLE;
            default:  n_state = DV_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            DV_IDLE: begin
                r_diff <= {i_req.sample[31], i_req.sample}
                        - {i_req.low_cut[31], i_req.low_cut};
                r_span <= {i_req.high_cut[31], i_req.high_cut}
                        - {i_req.low_cut[31], i_req.low_cut};
            end
            DV_ABS: begin
                r_mag_num   <= r_diff[32] ? 32'(-r_diff) : r_diff[31:0];
                r_mag_den   <= r_span[32] ? 32'(-r_span) : r_span[31:0];
                r_span_zero <= (r_span == '0);
                r_non_pos   <= (r_diff == '0) || (r_diff[32] != r_span[32]);
                r_diff_neg  <= r_diff[32];
            end
            DV_CHECK: begin
                if (r_span_zero) begin
                    r_quot <= r_diff_neg ? 8'd0 : INDEX_MAX;
                end else if (r_non_pos) begin
                    r_quot <= 8'd0;
                end else if (r_mag_num >= r_mag_den) begin
                    r_quot <= INDEX_MAX;
                end
                r_rem <= r_mag_num;
                r_cnt <= '0;
            end
            DV_ITER: begin
                if (take) begin
                    r_rem <= 32'(shifted - {1'b0, r_mag_den});
                end else begin
                    r_rem <= shifted[31:0];
                end
                r_quot <= {r_quot[6:0], take};
                r_cnt  <= r_cnt + 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_rsp.done  = (r_state == DV_DONE);
        o_rsp.index = r_quot;
    end

endmodule

// ===== rtl/core/pixel_window_level_palette_top.sv =====
// ----------------------------------------------------------------------------
// pixel_window_level_palette_top: window/level mapping through a palette
// Maps a signed grey sample to a colour index, looks it up in a 24-bit
// palette RAM and emits the colour with the mirrored destination index.
// ----------------------------------------------------------------------------
// A palette item (kind 1) is taken in the idle state and writes one palette
// entry. A pixel item (kind 0) passes through the index divider and then a
// read of the palette RAM before the next item can be accepted; the divider
// skips its iterations when the index saturates, the sample lies on the
// wrong side of the low cut or the two cuts are equal. The divider yields
// one quotient bit per cycle. Pixels are worked on one at a time; a finished
// result sits in an output register, so the next item is accepted while
// that result waits. The palette reads as zero after reset: each entry has a
// valid bit that reset clears, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module pixel_window_level_palette_top
    import pwlp_pkg::*;
#(
    parameter int PALETTE_DEPTH = PWLP_PALETTE_DEPTH,
    parameter int MAX_WINDOW    = PWLP_MAX_WINDOW
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Configuration write port.
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [31:0]            i_cfg_data,
    // Input item channel.
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  t_in_item               i_in_item,
    // Result item channel.
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output t_out_item              o_out_item
);

    localparam int PAL_AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

    // Configuration registers.
    logic signed [31:0] r_low_cut;
    logic signed [31:0] r_high_cut;
    logic [12:0]        r_win_width;
    logic [12:0]        r_win_height;
    logic               r_mirror_x;
    logic               r_mirror_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_cut    <= 32'sd0;
            r_high_cut   <= 32'sd255;
            r_win_width  <= 13'd1;
            r_win_height <= 13'd1;
            r_mirror_x   <= 1'b0;
            r_mirror_y   <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_LOW_CUT:       r_low_cut    <= i_cfg_data;
                CFG_HIGH_CUT:      r_high_cut   <= i_cfg_data;
                CFG_WINDOW_WIDTH:  r_win_width  <= i_cfg_data[12:0];
                CFG_WINDOW_HEIGHT: r_win_height <= i_cfg_data[12:0];
                CFG_MIRROR_X:      r_mirror_x   <= i_cfg_data[0];
                CFG_MIRROR_Y:      r_mirror_y   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Effective window size, held to 1..MAX_WINDOW.
    logic [12:0] width_eff;
    logic [12:0] height_eff;

    always_comb begin
        if (r_win_width == '0) begin
            width_eff = 13'd1;
        end else if ({19'd0, r_win_width} > 32'(MAX_WINDOW)) begin
            width_eff = 13'(MAX_WINDOW);
        end else begin
            width_eff = r_win_width;
        end
        if (r_win_height == '0) begin
            height_eff = 13'd1;
        end else if ({19'd0, r_win_height} > 32'(MAX_WINDOW)) begin
            height_eff = 13'(MAX_WINDOW);
        end else begin
            height_eff = r_win_height;
        end
    end

    // Control.
    t_state r_state;
    t_state n_state;

    logic      in_accept;
    logic      is_pixel;
    logic      out_free;
    logic      out_load;
    logic      pal_in_range;
    logic      ram_we;
    logic      ram_re;
    t_div_req  div_req;
    t_div_rsp  div_rsp;
    logic      r_out_valid;
    t_out_item r_out_item;

    assign in_accept    = i_in_valid && !o_in_stall;
    assign is_pixel     = (i_in_item.kind == KIND_PIXEL);
    assign out_free     = !r_out_valid || !i_out_stall;
    assign pal_in_range = ({1'b0, i_in_item.palette_index} < 9'(PALETTE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_accept && is_pixel) begin
                    n_state = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                if (div_rsp.done) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall       = (r_state != ST_IDLE);
        div_req.start    = (r_state == ST_IDLE) && in_accept && is_pixel;
        div_req.sample   = i_in_item.pixel_value;
        div_req.low_cut  = r_low_cut;
        div_req.high_cut = r_high_cut;
        ram_we           = (r_state == ST_IDLE) && in_accept && !is_pixel && pal_in_range;
        ram_re           = (r_state == ST_DIVIDE) && div_rsp.done;
        out_load         = (r_state == ST_READ) && out_free;
    end

    pwlp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Palette storage. The valid bits make never-written entries read as zero.
    logic [PALETTE_DEPTH-1:0] r_pal_valid;
    logic [23:0]              ram_rdata;
    logic                     idx_in_range;

    assign idx_in_range = ({1'b0, div_rsp.index} < 9'(PALETTE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pal_valid <= '0;
        end else if (ram_we) begin
            r_pal_valid[i_in_item.palette_index[PAL_AW-1:0]] <= 1'b1;
        end
    end

    pwlp_ram #(
        .WIDTH (24),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_in_item.palette_index[PAL_AW-1:0]),
        .i_wdata (i_in_item.palette_color),
        .i_re    (ram_re),
        .i_raddr (div_rsp.index[PAL_AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // Destination: column mirrored on mirror X, row on !mirror Y; row*width+col.
    logic [23:0] r_dcol;
    logic [23:0] r_drow;
    logic [23:0] r_prod;
    logic [23:0] r_dest;
    logic [7:0]  r_ci;
    logic        r_hit;

    always_ff @(posedge i_clk) begin
        if (div_req.start) begin
            r_dcol <= r_mirror_x
                    ? 24'(width_eff) - 24'd1 - 24'(i_in_item.column)
                    : 24'(i_in_item.column);
            r_drow <= !r_mirror_y
                    ? 24'(height_eff) - 24'd1 - 24'(i_in_item.row)
                    : 24'(i_in_item.row);
        end
        r_prod <= 24'(r_drow * 24'(width_eff));
        r_dest <= r_prod + r_dcol;
        if (ram_re) begin
            r_ci  <= div_rsp.index;
            r_hit <= idx_in_range && r_pal_valid[div_rsp.index[PAL_AW-1:0]];
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_item.color       <= r_hit ? ram_rdata : 24'd0;
            r_out_item.dest_index  <= r_dest;
            r_out_item.color_index <= r_ci;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // A new result only comes out of the palette read state.
    a_out_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == ST_READ)
        else $error("result appeared without a palette read");

    // Palette writes never overlap a pixel in flight.
    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> r_state == ST_IDLE)
        else $error("palette write while a pixel is in flight");

    // The divider only finishes while the control waits for it.
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> r_state == ST_DIVIDE)
        else $error("divider finished outside the divide state");

    // An index past the palette depth gives a black pixel.
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && ({1'b0, r_out_item.color_index} >= 9'(PALETTE_DEPTH)))
        |-> r_out_item.color == 24'd0)
        else $error("colour read beyond the palette depth");

endmodule
